[design/dkca_pkg.sv]
// ----------------------------------------------------------------------------
// dkca_pkg
// Shared types and constants for the dual key color alpha unit: register
// indexes and reset values, datapath widths and the word handed cell to cell.
// ----------------------------------------------------------------------------
package dkca_pkg;

  // config register index
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RED   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_GREEN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_BLUE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RED   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_GREEN = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_BLUE  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_TOL   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_TOL   = 4'd7;

  // reset values of the config registers
  localparam logic [7:0] RST_INNER_RED   = 8'd0;
  localparam logic [7:0] RST_INNER_GREEN = 8'd255;
  localparam logic [7:0] RST_INNER_BLUE  = 8'd0;
  localparam logic [7:0] RST_OUTER_RED   = 8'd0;
  localparam logic [7:0] RST_OUTER_GREEN = 8'd200;
  localparam logic [7:0] RST_OUTER_BLUE  = 8'd0;
  localparam logic [7:0] RST_INNER_TOL   = 8'd50;
  localparam logic [7:0] RST_OUTER_TOL   = 8'd100;

  // datapath widths
  localparam int CHAN_W = 8;   // color channel and alpha
  localparam int SQ_W   = 16;  // square of an 8-bit value
  localparam int DIST_W = 18;  // sum of three squares
  localparam int PROD_W = 36;  // scaled squared distance and trial products

  // number of search cells (one per alpha bit) and total latency
  localparam int NUM_CELLS   = CHAN_W;
  localparam int FRONT_DEPTH = 3;
  localparam int LATENCY     = FRONT_DEPTH + NUM_CELLS + 1;

  typedef struct packed {
    logic [CHAN_W-1:0] inner_red;
    logic [CHAN_W-1:0] inner_green;
    logic [CHAN_W-1:0] inner_blue;
    logic [CHAN_W-1:0] outer_red;
    logic [CHAN_W-1:0] outer_green;
    logic [CHAN_W-1:0] outer_blue;
    logic [CHAN_W-1:0] inner_tolerance;
    logic [CHAN_W-1:0] outer_tolerance;
  } cfg_t;

  // word passed along the cell chain
  // q2t/qt: m^2*ti^2 and m*ti^2 for the inner remainder m = 255 - k_inner
  // p2t/pt: k^2*to^2 and k*to^2 for the outer prefix k
  typedef struct packed {
    logic              valid;
    logic              outer_zero;
    logic [PROD_W-1:0] x;
    logic [PROD_W-1:0] y;
    logic [PROD_W-1:0] q2t;
    logic [PROD_W-1:0] qt;
    logic [PROD_W-1:0] p2t;
    logic [PROD_W-1:0] pt;
    logic [SQ_W-1:0]   tol2_i;
    logic [SQ_W-1:0]   tol2_o;
    logic [CHAN_W-1:0] ki;
    logic [CHAN_W-1:0] ko;
  } item_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[design/dkca_front.sv]
// ----------------------------------------------------------------------------
// dkca_front
// Front pipeline: squared channel distances, squared tolerances, and the
// 65025-scaled distances and start values that seed the search cells.
// ----------------------------------------------------------------------------
module dkca_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [dkca_pkg::CHAN_W-1:0] pixel_red,
  input  logic [dkca_pkg::CHAN_W-1:0] pixel_green,
  input  logic [dkca_pkg::CHAN_W-1:0] pixel_blue,
  input  dkca_pkg::cfg_t              cfg,
  output dkca_pkg::item_t             seed
);

  localparam int SQ_W   = dkca_pkg::SQ_W;
  localparam int DIST_W = dkca_pkg::DIST_W;
  localparam int PROD_W = dkca_pkg::PROD_W;

  // stage 1 registers
  logic              s1_valid;
  logic              s1_outer_zero;
  logic [SQ_W-1:0]   s1_sq_i [3];
  logic [SQ_W-1:0]   s1_sq_o [3];
  logic [SQ_W-1:0]   s1_tol2_i;
  logic [SQ_W-1:0]   s1_tol2_o;

  // stage 2 registers
  logic              s2_valid;
  logic              s2_outer_zero;
  logic [DIST_W-1:0] s2_di2;
  logic [DIST_W-1:0] s2_do2;
  logic [PROD_W-1:0] s2_qt;
  logic [SQ_W-1:0]   s2_tol2_i;
  logic [SQ_W-1:0]   s2_tol2_o;

  // stage 3 register
  dkca_pkg::item_t   s3;

  // per-channel differences
  logic [dkca_pkg::CHAN_W-1:0] dif_i [3];
  logic [dkca_pkg::CHAN_W-1:0] dif_o [3];

  always_comb begin
    dif_i[0] = dkca_pkg::abs_diff(pixel_red,   cfg.inner_red);
    dif_i[1] = dkca_pkg::abs_diff(pixel_green, cfg.inner_green);
    dif_i[2] = dkca_pkg::abs_diff(pixel_blue,  cfg.inner_blue);
    dif_o[0] = dkca_pkg::abs_diff(pixel_red,   cfg.outer_red);
    dif_o[1] = dkca_pkg::abs_diff(pixel_green, cfg.outer_green);
    dif_o[2] = dkca_pkg::abs_diff(pixel_blue,  cfg.outer_blue);
  end

  // stage 1: squares of differences and tolerances
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    for (int c = 0; c < 3; c++) begin
      s1_sq_i[c] <= SQ_W'(dif_i[c]) * SQ_W'(dif_i[c]);
      s1_sq_o[c] <= SQ_W'(dif_o[c]) * SQ_W'(dif_o[c]);
    end
    s1_tol2_i     <= SQ_W'(cfg.inner_tolerance) * SQ_W'(cfg.inner_tolerance);
    s1_tol2_o     <= SQ_W'(cfg.outer_tolerance) * SQ_W'(cfg.outer_tolerance);
    s1_outer_zero <= (cfg.outer_tolerance == '0);
  end

  // stage 2: squared distances, 255 * inner tolerance squared
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_di2 <= DIST_W'(s1_sq_i[0]) + DIST_W'(s1_sq_i[1]) + DIST_W'(s1_sq_i[2]);
    s2_do2 <= DIST_W'(s1_sq_o[0]) + DIST_W'(s1_sq_o[1]) + DIST_W'(s1_sq_o[2]);
    s2_qt  <= (PROD_W'(s1_tol2_i) << 8) - PROD_W'(s1_tol2_i);
    s2_tol2_i     <= s1_tol2_i;
    s2_tol2_o     <= s1_tol2_o;
    s2_outer_zero <= s1_outer_zero;
  end

  // stage 3: scale distances by 65025 = 2^16 - 2^9 + 1, seed the search
  always_ff @(posedge clk) begin
    s3.x <= (PROD_W'(s2_di2) << 16) - (PROD_W'(s2_di2) << 9) + PROD_W'(s2_di2);
    s3.y <= (PROD_W'(s2_do2) << 16) - (PROD_W'(s2_do2) << 9) + PROD_W'(s2_do2);
    s3.q2t        <= (s2_qt << 8) - s2_qt;
    s3.qt         <= s2_qt;
    s3.p2t        <= '0;
    s3.pt         <= '0;
    s3.tol2_i     <= s2_tol2_i;
    s3.tol2_o     <= s2_tol2_o;
    s3.ki         <= '0;
    s3.ko         <= '0;
    s3.outer_zero <= s2_outer_zero;
    if (rst) begin
      s3.valid <= 1'b0;
    end else begin
      s3.valid <= s2_valid;
    end
  end

  assign seed = s3;

endmodule

[design/dkca_cell.sv]
// ----------------------------------------------------------------------------
// dkca_cell
// One search cell: decides one bit of the inner and the outer alpha term by
// a trial squared compare, then hands the updated word to the next cell.
// ----------------------------------------------------------------------------
module dkca_cell #(
  parameter int BIT = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  dkca_pkg::item_t din,
  output dkca_pkg::item_t dout
);

  localparam int PROD_W = dkca_pkg::PROD_W;

  logic [PROD_W-1:0] cand_i;
  logic [PROD_W-1:0] cand_o;
  logic              hit_i;
  logic              hit_o;
  dkca_pkg::item_t   stage;
  dkca_pkg::item_t   stage_next;

  // trial values: inner (m - 2^b)^2 * ti^2, outer (k + 2^b)^2 * to^2
  always_comb begin
    cand_i = din.q2t + (PROD_W'(din.tol2_i) << (2 * BIT)) - (din.qt << (BIT + 1));
    cand_o = din.p2t + (PROD_W'(din.tol2_o) << (2 * BIT)) + (din.pt << (BIT + 1));
    hit_i  = (din.x <= cand_i);
    hit_o  = (cand_o <= din.y);
  end

  // keep the bit where the trial holds and fold it into the running products
  always_comb begin
    stage_next = din;
    stage_next.ki[BIT] = hit_i;
    stage_next.ko[BIT] = hit_o;
    if (hit_i) begin
      stage_next.q2t = cand_i;
      stage_next.qt  = din.qt - (PROD_W'(din.tol2_i) << BIT);
    end
    if (hit_o) begin
      stage_next.p2t = cand_o;
      stage_next.pt  = din.pt + (PROD_W'(din.tol2_o) << BIT);
    end
  end

  // cell register, cleared on reset so no stale word is marked valid
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

  assign dout = stage;

endmodule

[design/dual_key_color_alpha_unit.sv]
// ----------------------------------------------------------------------------
// dual_key_color_alpha_unit
// Chroma key alpha from an inner and an outer key color: exact
// floor(255 * max(inner term, outer term)) by squared integer compares.
//
//   channel   signals                                   direction
//   pixel     start, busy, pixel_red/green/blue         in
//   result    done, key_alpha                           out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// One pixel is taken every clock; busy stays low. The alpha appears on
// done after three front stages, eight search cells (one per alpha bit)
// and an output register. rst clears the pipeline valid bits and loads
// the register reset values. The result side has no stall.
// ----------------------------------------------------------------------------
module dual_key_color_alpha_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [dkca_pkg::CHAN_W-1:0]    pixel_red,
  input  logic [dkca_pkg::CHAN_W-1:0]    pixel_green,
  input  logic [dkca_pkg::CHAN_W-1:0]    pixel_blue,
  output logic                           done,
  output logic [dkca_pkg::CHAN_W-1:0]    key_alpha,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dkca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dkca_pkg::CHAN_W-1:0]    cfg_data
);

  localparam int NUM_CELLS = dkca_pkg::NUM_CELLS;

  dkca_pkg::cfg_t  cfg;
  dkca_pkg::item_t chain [NUM_CELLS+1];
  logic            accept;
  logic [dkca_pkg::CHAN_W-1:0] outer_term;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inner_red       <= dkca_pkg::RST_INNER_RED;
      cfg.inner_green     <= dkca_pkg::RST_INNER_GREEN;
      cfg.inner_blue      <= dkca_pkg::RST_INNER_BLUE;
      cfg.outer_red       <= dkca_pkg::RST_OUTER_RED;
      cfg.outer_green     <= dkca_pkg::RST_OUTER_GREEN;
      cfg.outer_blue      <= dkca_pkg::RST_OUTER_BLUE;
      cfg.inner_tolerance <= dkca_pkg::RST_INNER_TOL;
      cfg.outer_tolerance <= dkca_pkg::RST_OUTER_TOL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dkca_pkg::REG_INNER_RED:   cfg.inner_red       <= cfg_data;
        dkca_pkg::REG_INNER_GREEN: cfg.inner_green     <= cfg_data;
        dkca_pkg::REG_INNER_BLUE:  cfg.inner_blue      <= cfg_data;
        dkca_pkg::REG_OUTER_RED:   cfg.outer_red       <= cfg_data;
        dkca_pkg::REG_OUTER_GREEN: cfg.outer_green     <= cfg_data;
        dkca_pkg::REG_OUTER_BLUE:  cfg.outer_blue      <= cfg_data;
        dkca_pkg::REG_INNER_TOL:   cfg.inner_tolerance <= cfg_data;
        dkca_pkg::REG_OUTER_TOL:   cfg.outer_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // distance front end
  dkca_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .cfg         (cfg),
    .seed        (chain[0])
  );

  // search cells, most significant alpha bit first
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    dkca_cell #(
      .BIT (NUM_CELLS - 1 - g)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  // zero outer tolerance gives an outer term of zero
  assign outer_term = chain[NUM_CELLS].outer_zero ? '0 : chain[NUM_CELLS].ko;

  // output register: larger of the two terms
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[NUM_CELLS].valid;
    end
    key_alpha <= (chain[NUM_CELLS].ki > outer_term) ? chain[NUM_CELLS].ki : outer_term;
  end

endmodule

[design/dkca_checker.sv]
// ----------------------------------------------------------------------------
// dkca_checker
// Port-level checks for the dual key color alpha unit: fixed latency from
// pixel to alpha in both directions, and an always-open config channel.
// ----------------------------------------------------------------------------
module dkca_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_valid,
  input logic cfg_ready
);

  localparam int LAT = dkca_pkg::LATENCY;

  // every accepted pixel yields one word after the pipeline latency
  a_pixel_to_alpha: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted pixel gave no alpha word");

  // no alpha word without an accepted pixel
  a_alpha_from_pixel: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LAT))
    else $error("alpha word without a matching pixel");

  // pixels are never refused
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("pixel refused");

  // config writes are always taken
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> (cfg_ready && $stable(cfg_ready)))
    else $error("config write stalled");

endmodule

bind dual_key_color_alpha_unit dkca_checker u_dkca_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
